// ----- hw/rtl/ffpa_pkg.sv -----
// Shared constants and types for the first-fit page allocator.
`default_nettype none
package ffpa_pkg;
  localparam int FreeSlotsDef   = 64;
  localparam int PageBytesDef   = 4096;
  localparam int GrowGranuleDef = 32;
  localparam int AddrW = 48;
  localparam int CntW  = 21;
  localparam int PageW = 20;
  localparam logic [CntW-1:0] MaxPool = 21'd1048576;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_POOL = 1'b1;

  typedef struct packed {
    logic [PageW-1:0] start;
    logic [CntW-1:0]  len;
  } extent_t;
endpackage
`default_nettype wire

// ----- hw/rtl/first_fit_page_allocator_core.sv -----
// Top level: first-fit page allocator with a sequencer over the extent memory.
//
//  channel | signals                                   | dir
//  req     | req_valid/req_ready op page_count block_address | in
//  rsp     | rsp_valid/rsp_ready status granted_address granted_pages | out
//  cfg     | cfg_we cfg_index cfg_data                  | in
//
// A request scans the stored extents; an allocate that grows the pool scans, inserts
// and rescans.
// The scan and shift loops each touch one memory entry at a time (one read port).
// Reset empties the table at once by zeroing the extent count; no clearing pass.
// A request is taken while the previous word waits in the output register; the new
// result holds in S_DONE until that word is accepted.
`default_nettype none
module first_fit_page_allocator_core #(
  parameter int FreeSlots   = ffpa_pkg::FreeSlotsDef,
  parameter int PageBytes   = ffpa_pkg::PageBytesDef,
  parameter int GrowGranule = ffpa_pkg::GrowGranuleDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic        op,
  input  wire logic [20:0] page_count,
  input  wire logic [47:0] block_address,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [1:0]       status,
  output logic [47:0]      granted_address,
  output logic [20:0]      granted_pages,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data
);
  localparam int IdxW  = $clog2(FreeSlots);
  localparam int CntNW = $clog2(FreeSlots + 1);
  localparam int ShW   = $clog2(PageBytes);
  localparam logic [CntNW-1:0] FullCnt = CntNW'(FreeSlots);
  localparam logic [22:0] GranM1 = 23'(GrowGranule - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_ARD, S_GROW, S_FSCAN, S_FRD, S_FDEC,
    S_SHL, S_SHR, S_WR, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    FM_GRANT, FM_MERGE, FM_INSERT
  } fmode_t;

  state_t            state;
  logic [47:0]       base_address;
  logic [20:0]       pool_pages;
  logic [CntNW-1:0]  count;
  logic [20:0]       carve;
  logic              r_op;
  logic [20:0]       r_n;
  logic [20:0]       r_page;   // page being freed or grown
  logic [20:0]       r_len;
  logic              retry;
  logic [CntNW-1:0]  pos;
  logic [CntNW-1:0]  sh;       // shift cursor
  logic              have_prev;
  ffpa_pkg::extent_t prev;
  logic              rvalid;   // rd valid for pos
  fmode_t            fmode;    // grant, merge or insert action
  logic [20:0]       grant_page;
  logic [1:0]        res_status;
  logic [47:0]       res_gaddr;
  logic [20:0]       res_gpages;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  ffpa_pkg::extent_t ram_wdata, rd;
  ffpa_pkg::extent_t wr_ent;
  logic [IdxW-1:0]   wr_idx;

  ffpa_extent_ram #(.Depth(FreeSlots)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rd)
  );

  logic [20:0] limit;
  assign limit = (pool_pages > ffpa_pkg::MaxPool) ? ffpa_pkg::MaxPool : pool_pages;

  logic [22:0] grow23;
  logic [20:0] grow;
  assign grow23 = (23'(r_n) + GranM1) / 23'(GrowGranule) * 23'(GrowGranule);
  assign grow   = grow23[20:0];

  logic [47:0] off;
  assign off = block_address - base_address;

  // combinational read address and write port
  always_comb begin
    ram_raddr = pos[IdxW-1:0];
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_wdata = wr_ent;
    if (state == S_SHL) begin
      ram_raddr = IdxW'(sh - CntNW'(1));
      ram_we    = rvalid;
      ram_waddr = IdxW'(sh - CntNW'(2));
      ram_wdata = rd;
    end else if (state == S_SHR) begin
      ram_raddr = IdxW'(sh - CntNW'(2));
      ram_we    = rvalid;
      ram_waddr = IdxW'(sh - CntNW'(1));
      ram_wdata = rd;
    end else if (state == S_WR) begin
      ram_we = 1'b1;
    end
  end

  logic [21:0] pend, fend;
  assign pend = 22'(prev.start) + 22'(prev.len);
  assign fend = 22'(r_page) + 22'(r_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base_address <= '0;
      pool_pages   <= '0;
      count        <= '0;
      carve        <= '0;
      rsp_valid    <= 1'b0;
      rvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ffpa_pkg::CFG_BASE) base_address <= cfg_data;
        else pool_pages <= cfg_data[20:0];
      end
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      rvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            r_op <= op; r_n <= page_count; retry <= 1'b0;
            pos <= '0; have_prev <= 1'b0;
            res_status <= ffpa_pkg::ST_OK;
            res_gaddr <= '0; res_gpages <= '0;
            if (op == ffpa_pkg::OP_ALLOC) begin
              state <= (page_count == '0) ? S_DONE : S_ASCAN;
            end else begin
              r_page <= 21'(off >> ShW); r_len <= page_count;
              if (block_address >= base_address && page_count != '0 &&
                  off[ShW-1:0] == '0 &&
                  (49'(off >> ShW) + 49'(page_count)) <= 49'(limit)) begin
                state <= S_FSCAN;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_ASCAN: begin
          if (pos >= count) state <= retry ? S_DONE : S_GROW;
          else state <= S_ARD;
          if (pos >= count && retry) res_status <= ffpa_pkg::ST_OOM;
        end
        S_ARD: begin
          if (rd.len >= r_n) begin
            if (rd.len == r_n) begin
              grant_page <= 21'(rd.start);
              sh <= pos + CntNW'(2); rvalid <= 1'b0;
              state <= S_SHL; fmode <= FM_GRANT;
            end else begin
              wr_ent.start <= rd.start;
              wr_ent.len   <= rd.len - r_n;
              wr_idx <= pos[IdxW-1:0];
              grant_page <= 21'(rd.start) + 21'(rd.len - r_n);
              state <= S_WR; fmode <= FM_GRANT;
            end
            res_gpages <= r_n;
          end else begin
            pos <= pos + 1'b1; state <= S_ASCAN;
          end
        end
        S_GROW: begin
          if (23'(carve) + grow23 > 23'(limit)) begin
            res_status <= ffpa_pkg::ST_OOM; state <= S_DONE;
          end else begin
            r_page <= carve; r_len <= grow;
            pos <= '0; have_prev <= 1'b0; state <= S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (pos >= count) state <= S_FDEC;
          else state <= S_FRD;
        end
        S_FRD: begin
          if (21'(rd.start) <= r_page) begin
            prev <= rd; have_prev <= 1'b1;
            pos <= pos + 1'b1; state <= S_FSCAN;
          end else begin
            state <= S_FDEC; rvalid <= 1'b1;
          end
        end
        S_FDEC: begin
          // rd still holds entry pos when rvalid
          if (have_prev && pend == fend - 22'(r_len) &&
              rvalid && fend == 22'(rd.start)) begin
            wr_ent.start <= prev.start;
            wr_ent.len   <= prev.len + r_len + rd.len;
            wr_idx <= IdxW'(pos - 1'b1);
            sh <= pos + CntNW'(2); fmode <= FM_MERGE; state <= S_SHL;
          end else if (have_prev && pend == 22'(r_page)) begin
            wr_ent.start <= prev.start; wr_ent.len <= prev.len + r_len;
            wr_idx <= IdxW'(pos - 1'b1); fmode <= FM_MERGE; state <= S_WR;
          end else if (rvalid && fend == 22'(rd.start)) begin
            wr_ent.start <= r_page[19:0]; wr_ent.len <= rd.len + r_len;
            wr_idx <= pos[IdxW-1:0]; fmode <= FM_MERGE; state <= S_WR;
          end else if (count >= FullCnt) begin
            res_status <= ffpa_pkg::ST_FULL; state <= S_DONE;
          end else begin
            wr_ent.start <= r_page[19:0]; wr_ent.len <= r_len;
            wr_idx <= pos[IdxW-1:0];
            sh <= count + CntNW'(1); fmode <= FM_INSERT; state <= S_SHR;
          end
        end
        S_SHL: begin
          // move entry sh-1 to sh-2 for sh-1 < count
          if (rvalid) sh <= sh + 1'b1;
          if (sh > count && !rvalid) begin
            count <= count - 1'b1;
            state <= (fmode == FM_MERGE) ? S_WR : S_DONE;
            if (fmode == FM_GRANT) begin
              res_gaddr <= base_address + (48'(grant_page) << ShW);
            end
          end else if (!rvalid) begin
            rvalid <= 1'b1;
          end
        end
        S_SHR: begin
          // move entry sh-2 to sh-1, walking down to pos
          if (rvalid) sh <= sh - 1'b1;
          if (sh <= pos + CntNW'(1) && !rvalid) begin
            count <= count + 1'b1; state <= S_WR;
          end else if (!rvalid) begin
            rvalid <= 1'b1;
          end
        end
        S_WR: begin
          if (fmode == FM_GRANT) begin
            res_gaddr <= base_address + (48'(grant_page) << ShW);
            state <= S_DONE;
          end else if (r_op == ffpa_pkg::OP_ALLOC) begin
            carve <= carve + r_len; retry <= 1'b1;
            pos <= '0; state <= S_ASCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            status <= res_status;
            granted_address <= res_gaddr;
            granted_pages <= res_gpages;
            rsp_valid <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
endmodule
`default_nettype wire

// ----- hw/rtl/ffpa_extent_ram.sv -----
// Extent table memory: one write port, one registered read port.
`default_nettype none
module ffpa_extent_ram #(
  parameter int Depth = ffpa_pkg::FreeSlotsDef,
  localparam int IdxW = $clog2(Depth)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IdxW-1:0]      waddr,
  input  wire ffpa_pkg::extent_t    wdata,
  input  wire logic [IdxW-1:0]      raddr,
  output ffpa_pkg::extent_t         rdata
);
  ffpa_pkg::extent_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ffpa_checker.sv -----
// Port-level checks for the allocator, bound to the top level.
`default_nettype none
module ffpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  status,
  input wire logic [47:0] granted_address,
  input wire logic [20:0] granted_pages
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_pages))
    else $error("response dropped while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ffpa_pkg::ST_OK |-> granted_pages == '0 && granted_address == '0)
    else $error("error response carries a grant");
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= 2'(ffpa_pkg::ST_FULL))
    else $error("bad status code");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted two requests back to back");
endmodule

bind first_fit_page_allocator_core ffpa_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
  .granted_address(granted_address), .granted_pages(granted_pages)
);
`default_nettype wire
